@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RPBH_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpbh assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RPBH_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpbh assertion failed");

// Next-cycle implication that also holds across reset.
`define RPBH_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rpbh assertion failed");

`endif

@@ design/rpbh_pkg.sv @@
// Types, codes and field layout of the read position binning histogram.
package rpbh_pkg;

  // Default sizes of the histogram.
  localparam int NUM_CHROM_DEF      = 4;
  localparam int BINS_PER_CHROM_DEF = 65536;
  localparam int COUNT_WIDTH_DEF    = 32;

  // Chromosome length table slots: one per chrom code.
  localparam int CHROM_SLOTS = 4;

  // Position and interval widths.
  localparam int POS_W      = 32;
  localparam int IV_W       = 16;
  localparam int SHIFT_W    = 17;
  localparam int DIV_CNT_W  = $clog2(POS_W);

  // Stream layout.
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 56;

  // Input tdata field offsets (lowest bit of each field).
  localparam int IN_CHROM_LO  = 0;
  localparam int IN_FIRST_LO  = 2;
  localparam int IN_SECOND_LO = 34;
  localparam int IN_NEG_LO    = 66;
  localparam int IN_STRAND_LO = 67;
  localparam int IN_SEL_LO    = 69;
  localparam int IN_LEN_LO    = 85;

  // Output tdata field offsets.
  localparam int OUT_CHROM_LO   = 0;
  localparam int OUT_BIN_LO     = 2;
  localparam int OUT_COUNT_LO   = 18;
  localparam int OUT_SAT_LO     = 50;
  localparam int OUT_ASSUMED_LO = 51;

  // Request kinds.
  localparam logic [1:0] REQ_COUNT = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Strand codes; any code with the upper bit set is unknown.
  localparam logic [1:0] STRAND_PLUS  = 2'd0;
  localparam logic [1:0] STRAND_MINUS = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_READ_SHIFT   = 2'd1;
  localparam logic [1:0] REG_FIVE_PRIME   = 2'd2;
  localparam logic [1:0] REG_DROP_UNKNOWN = 2'd3;

  // Register reset values; a read shift of all ones selects half the interval.
  localparam logic [IV_W-1:0]    BIN_INTERVAL_RST = 16'd200;
  localparam logic [SHIFT_W-1:0] SHIFT_DEFAULT    = 17'h1FFFF;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_BEFORE   = 3'd1,
    ST_PAST     = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_RANGE    = 3'd4,
    ST_LOADED   = 3'd5,
    ST_READOUT  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORDER,
    S_CHECK,
    S_SHIFT,
    S_CLAMP,
    S_DIV,
    S_LOOK,
    S_UPDATE,
    S_EMIT
  } state_t;

endpackage

@@ design/rpbh_ram.sv @@
// Generic single-port-write, registered-read RAM.
module rpbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/read_position_binning_histogram_top.sv @@
// Top level of the read position binning histogram.
//
// Each request on the slave stream gives exactly one result on the master stream, in order.
// A count request holds the block from the cycle in which it is accepted through the
// accepting step, ordering, range checks, read shift and clamping, the bit-serial
// divider that forms one quotient bit per cycle, then reading the bin count, writing it
// back and loading the result register (an out-of-range bin skips the write). A length
// load, the spare request kind, a bad chromosome or a negative start goes straight from
// acceptance to the result register; a read past the chromosome end or a dropped unknown
// strand first passes ordering and range checks; a bin readout first reads the bin count.
// The last step waits while an untaken result still holds the result register. One
// request is in work at a time; the result register lets the next request in while a
// result still waits on m_tready. After reset the count RAM is swept to zero, one entry
// a cycle, all NUM_CHROM * BINS_PER_CHROM entries (262144 by default), while s_tready
// stays low; configuration writes are taken at any time and are meant to happen only
// while the block is idle.
module read_position_binning_histogram_top #(
  parameter int NUM_CHROM      = rpbh_pkg::NUM_CHROM_DEF,
  parameter int BINS_PER_CHROM = rpbh_pkg::BINS_PER_CHROM_DEF,
  parameter int COUNT_WIDTH    = rpbh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_index,
  input  logic [rpbh_pkg::SHIFT_W-1:0]     cfg_wdata,
  // requests
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // chrom, first_coord, second_coord, first_negative, strand, bin_select,
  // length_value, zero pad
  input  logic [rpbh_pkg::IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic [1:0]                       s_tuser,
  // results
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_chrom, out_bin, bin_count, count_saturated, strand_assumed, zero pad
  output logic [rpbh_pkg::OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [2:0]                       m_tuser
);

  localparam int DEPTH = NUM_CHROM * BINS_PER_CHROM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(BINS_PER_CHROM);
  localparam int PW    = rpbh_pkg::POS_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [rpbh_pkg::DIV_CNT_W-1:0] DIV_LAST = rpbh_pkg::DIV_CNT_W'(PW - 1);

  // configuration registers
  logic [rpbh_pkg::IV_W-1:0]    bin_interval;
  logic [rpbh_pkg::SHIFT_W-1:0] read_shift;
  logic                         use_five_prime;
  logic                         drop_unknown_strand;

  // control
  rpbh_pkg::state_t state, state_next;
  logic [AW-1:0]    clr_addr;
  logic [rpbh_pkg::DIV_CNT_W-1:0] div_cnt;

  // working registers
  logic [1:0]                  chrom_r;
  logic [1:0]                  strand_r;
  logic [PW-1:0]               lo, hi;
  logic [PW:0]                 pos;
  logic [rpbh_pkg::IV_W-1:0]   div_rem;
  logic [PW-1:0]               div_quo;
  logic [AW-1:0]               ram_addr;
  logic                        assumed;
  logic                        is_readout;
  logic [PW-1:0]               len_table [rpbh_pkg::CHROM_SLOTS];

  // staged result
  rpbh_pkg::status_t res_status;
  logic [1:0]        res_chrom;
  logic [15:0]       res_bin;
  logic [31:0]       res_count;
  logic              res_sat;
  logic              res_assumed;

  // combinational
  logic                       acc;
  logic [1:0]                 in_req, in_chrom, in_strand;
  logic [PW-1:0]              in_first, in_second, in_len;
  logic                       in_neg;
  logic [15:0]                in_sel;
  logic                       in_chrom_bad;
  logic [rpbh_pkg::IV_W-1:0]  iv;
  logic [rpbh_pkg::IV_W-1:0]  shift_val;
  logic [PW-1:0]              len_cur;
  logic                       minus, unknown;
  logic                       past_end, drop_it;
  logic [PW:0]                mid_sum, base_pos, shifted;
  logic [rpbh_pkg::IV_W:0]    div_trial;
  logic                       div_ge;
  logic                       bin_oor;
  logic [AW-1:0]              look_addr;
  logic                       out_free;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr;
  logic [COUNT_WIDTH-1:0]     ram_wdata, ram_rdata, cnt_next;
  logic                       cnt_sat;

  // field unpacking
  assign in_req    = s_tuser;
  assign in_chrom  = s_tdata[rpbh_pkg::IN_CHROM_LO  +: 2];
  assign in_first  = s_tdata[rpbh_pkg::IN_FIRST_LO  +: PW];
  assign in_second = s_tdata[rpbh_pkg::IN_SECOND_LO +: PW];
  assign in_neg    = s_tdata[rpbh_pkg::IN_NEG_LO];
  assign in_strand = s_tdata[rpbh_pkg::IN_STRAND_LO +: 2];
  assign in_sel    = s_tdata[rpbh_pkg::IN_SEL_LO    +: 16];
  assign in_len    = s_tdata[rpbh_pkg::IN_LEN_LO    +: PW];

  assign acc          = s_tvalid && s_tready;
  assign in_chrom_bad = 32'(in_chrom) >= 32'(NUM_CHROM);
  assign out_free     = !m_tvalid || m_tready;

  // zero interval acts as one
  assign iv = (bin_interval == '0) ? rpbh_pkg::IV_W'(1) : bin_interval;

  always_comb begin
    if (read_shift == rpbh_pkg::SHIFT_DEFAULT) begin
      shift_val = iv >> 1;
    end else if (read_shift[rpbh_pkg::SHIFT_W-1]) begin
      shift_val = '0;
    end else begin
      shift_val = read_shift[rpbh_pkg::IV_W-1:0];
    end
  end

  assign len_cur  = len_table[chrom_r];
  assign minus    = strand_r == rpbh_pkg::STRAND_MINUS;
  assign unknown  = strand_r[1];
  assign past_end = hi > len_cur;
  assign drop_it  = unknown && drop_unknown_strand;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};

  always_comb begin
    if (use_five_prime) begin
      base_pos = {1'b0, (minus ? hi : lo)};
    end else begin
      base_pos = {1'b0, mid_sum[PW:1]};
    end
  end

  always_comb begin
    if (minus) begin
      shifted = (pos < (PW+1)'(shift_val)) ? '0 : pos - (PW+1)'(shift_val);
    end else begin
      shifted = pos + (PW+1)'(shift_val);
    end
  end

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign div_trial = {div_rem, div_quo[PW-1]};
  assign div_ge    = div_trial >= {1'b0, iv};

  assign bin_oor   = div_quo >= 32'(BINS_PER_CHROM);
  assign look_addr = AW'(32'(chrom_r) * 32'(BINS_PER_CHROM)) + AW'(div_quo[BW-1:0]);

  assign cnt_sat  = ram_rdata == CNT_MAX;
  assign cnt_next = cnt_sat ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rpbh_pkg::S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = rpbh_pkg::S_IDLE;
        end
      end
      rpbh_pkg::S_IDLE: begin
        if (acc) begin
          case (in_req)
            rpbh_pkg::REQ_COUNT: begin
              if (in_chrom_bad || in_neg) begin
                state_next = rpbh_pkg::S_EMIT;
              end else begin
                state_next = rpbh_pkg::S_ORDER;
              end
            end
            rpbh_pkg::REQ_READ: begin
              if (in_chrom_bad) begin
                state_next = rpbh_pkg::S_EMIT;
              end else begin
                state_next = rpbh_pkg::S_LOOK;
              end
            end
            default: state_next = rpbh_pkg::S_EMIT;
          endcase
        end
      end
      rpbh_pkg::S_ORDER: state_next = rpbh_pkg::S_CHECK;
      rpbh_pkg::S_CHECK: begin
        if (past_end || drop_it) begin
          state_next = rpbh_pkg::S_EMIT;
        end else begin
          state_next = rpbh_pkg::S_SHIFT;
        end
      end
      rpbh_pkg::S_SHIFT: state_next = rpbh_pkg::S_CLAMP;
      rpbh_pkg::S_CLAMP: state_next = rpbh_pkg::S_DIV;
      rpbh_pkg::S_DIV: begin
        if (div_cnt == DIV_LAST) begin
          state_next = rpbh_pkg::S_LOOK;
        end
      end
      rpbh_pkg::S_LOOK: begin
        if (bin_oor) begin
          state_next = rpbh_pkg::S_EMIT;
        end else begin
          state_next = rpbh_pkg::S_UPDATE;
        end
      end
      rpbh_pkg::S_UPDATE: state_next = rpbh_pkg::S_EMIT;
      rpbh_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = rpbh_pkg::S_IDLE;
        end
      end
      default: state_next = rpbh_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ram_addr;
    ram_wdata = cnt_next;
    case (state)
      rpbh_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      rpbh_pkg::S_IDLE:   s_tready = 1'b1;
      rpbh_pkg::S_LOOK:   ram_re   = !bin_oor;
      rpbh_pkg::S_UPDATE: ram_we   = !is_readout;
      default: begin
      end
    endcase
  end

  rpbh_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(DEPTH)
  ) u_count_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(look_addr),
    .rd_data(ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= rpbh_pkg::S_CLEAR;
      clr_addr            <= '0;
      div_cnt             <= '0;
      m_tvalid            <= 1'b0;
      bin_interval        <= rpbh_pkg::BIN_INTERVAL_RST;
      read_shift          <= rpbh_pkg::SHIFT_DEFAULT;
      use_five_prime      <= 1'b0;
      drop_unknown_strand <= 1'b0;
      for (int i = 0; i < rpbh_pkg::CHROM_SLOTS; i++) begin
        len_table[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == rpbh_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == rpbh_pkg::S_CLAMP) begin
        div_cnt <= '0;
      end else if (state == rpbh_pkg::S_DIV) begin
        div_cnt <= div_cnt + rpbh_pkg::DIV_CNT_W'(1);
      end
      if (state == rpbh_pkg::S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          rpbh_pkg::REG_BIN_INTERVAL: bin_interval <= cfg_wdata[rpbh_pkg::IV_W-1:0];
          rpbh_pkg::REG_READ_SHIFT:   read_shift   <= cfg_wdata;
          rpbh_pkg::REG_FIVE_PRIME:   use_five_prime <= cfg_wdata[0];
          rpbh_pkg::REG_DROP_UNKNOWN: drop_unknown_strand <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (acc && in_req == rpbh_pkg::REQ_LOAD && !in_chrom_bad) begin
        len_table[in_chrom] <= in_len;
      end
    end
  end

  // datapath and staged result
  always_ff @(posedge clk) begin
    case (state)
      rpbh_pkg::S_IDLE: begin
        if (acc) begin
          chrom_r     <= in_chrom;
          strand_r    <= in_strand;
          lo          <= in_first;
          hi          <= in_second;
          assumed     <= 1'b0;
          is_readout  <= in_req == rpbh_pkg::REQ_READ;
          div_quo     <= 32'(in_sel);
          res_chrom   <= in_chrom;
          res_bin     <= '0;
          res_count   <= '0;
          res_sat     <= 1'b0;
          res_assumed <= 1'b0;
          res_status  <= rpbh_pkg::ST_RANGE;
          case (in_req)
            rpbh_pkg::REQ_COUNT: begin
              if (!in_chrom_bad) begin
                res_status <= rpbh_pkg::ST_BEFORE;
              end
            end
            rpbh_pkg::REQ_LOAD: begin
              if (!in_chrom_bad) begin
                res_status <= rpbh_pkg::ST_LOADED;
              end
            end
            rpbh_pkg::REQ_READ: begin
            end
            default: res_chrom <= '0;
          endcase
        end
      end
      rpbh_pkg::S_ORDER: begin
        if (lo > hi) begin
          lo <= hi;
          hi <= lo;
        end
      end
      rpbh_pkg::S_CHECK: begin
        pos     <= base_pos;
        assumed <= unknown;
        if (past_end) begin
          res_status <= rpbh_pkg::ST_PAST;
        end else begin
          res_status <= rpbh_pkg::ST_DROPPED;
        end
      end
      rpbh_pkg::S_SHIFT: pos <= shifted;
      rpbh_pkg::S_CLAMP: begin
        div_rem <= '0;
        div_quo <= (pos > (PW+1)'(len_cur)) ? len_cur : pos[PW-1:0];
      end
      rpbh_pkg::S_DIV: begin
        div_quo <= {div_quo[PW-2:0], div_ge};
        div_rem <= div_ge ? rpbh_pkg::IV_W'(div_trial - {1'b0, iv})
                          : div_trial[rpbh_pkg::IV_W-1:0];
      end
      rpbh_pkg::S_LOOK: begin
        ram_addr    <= look_addr;
        res_bin     <= div_quo[15:0];
        res_assumed <= assumed;
        res_status  <= rpbh_pkg::ST_RANGE;
      end
      rpbh_pkg::S_UPDATE: begin
        if (is_readout) begin
          res_status <= rpbh_pkg::ST_READOUT;
          res_count  <= 32'(ram_rdata);
        end else begin
          res_status <= rpbh_pkg::ST_COUNTED;
          res_count  <= 32'(cnt_next);
          res_sat    <= cnt_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == rpbh_pkg::S_EMIT && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {4'b0, res_assumed, res_sat, res_count, res_bin, res_chrom};
    end
  end

endmodule

@@ design/rpbh_checker.sv @@
// Port-level checker for the read position binning histogram, bound to the top level.
`include "assert_macros.svh"

module rpbh_checker #(
  parameter int COUNT_WIDTH = rpbh_pkg::COUNT_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rpbh_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [2:0]                       m_tuser
);

  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [31:0] count_f;
  logic        sat_f;
  logic        has_count;

  assign count_f   = m_tdata[rpbh_pkg::OUT_COUNT_LO +: 32];
  assign sat_f     = m_tdata[rpbh_pkg::OUT_SAT_LO];
  assign has_count = m_tuser == rpbh_pkg::ST_COUNTED || m_tuser == rpbh_pkg::ST_READOUT;

  // a held result keeps its payload
  `RPBH_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // one request in work at a time
  `RPBH_ASSERT_NXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // results without a bin count carry zero count and no saturation
  `RPBH_ASSERT_IMP(a_no_count, clk, rst, m_tvalid && !has_count, count_f == 32'd0 && !sat_f)
  // a saturated count is a counted read at the top of the range
  `RPBH_ASSERT_IMP(a_sat_max, clk, rst, m_tvalid && sat_f, m_tuser == rpbh_pkg::ST_COUNTED && count_f == CNT_MAX)
  // reset empties the result register
  `RPBH_ASSERT_NXT_ALWAYS(a_rst_clear, clk, rst, !m_tvalid)

endmodule

bind read_position_binning_histogram_top rpbh_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_rpbh_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

@@ tb/bin_histogram_checker.sv @@
`timescale 1ns / 1ps
// Checker for the read position binning histogram: predicts every result and compares it.
module bin_histogram_checker
  import rpbh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [SHIFT_W-1:0]     cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [2:0]             m_tuser,
  output int                     failures,
  output int                     pending,
  output int                     results_checked
);

  typedef struct packed {
    status_t     status;
    logic [1:0]  chrom;
    logic [15:0] bin;
    logic [31:0] count;
    logic        sat;
    logic        assumed;
  } bin_result_t;

  // Local copy of the registers and of the block's storage.
  logic [IV_W-1:0]    interval_q;
  logic [SHIFT_W-1:0] shift_q;
  logic               five_prime_q;
  logic               drop_unknown_q;
  logic [31:0]        chrom_len [CHROM_SLOTS];
  logic [31:0]        bin_tally [logic [17:0]];

  bin_result_t pending_results [$];

  function automatic bin_result_t predict_bin_update(input logic [1:0] req,
                                                     input logic [IN_TDATA_W-1:0] req_data);
    bin_result_t r;
    logic [1:0]  chrom;
    logic [1:0]  strand;
    logic [15:0] sel;
    logic [63:0] a, b, lo, hi, len, iv, shift, pos, bin;
    logic [17:0] slot;
    logic [31:0] tally;
    logic        minus;
    r        = '0;
    r.status = ST_RANGE;
    chrom    = req_data[IN_CHROM_LO +: 2];
    strand   = req_data[IN_STRAND_LO +: 2];
    sel      = req_data[IN_SEL_LO +: 16];
    a        = 64'(req_data[IN_FIRST_LO +: 32]);
    b        = 64'(req_data[IN_SECOND_LO +: 32]);
    case (req)
      REQ_LOAD: begin
        chrom_len[chrom] = req_data[IN_LEN_LO +: 32];
        r.status = ST_LOADED;
        r.chrom  = chrom;
      end
      REQ_READ: begin
        slot     = {chrom, sel};
        r.status = ST_READOUT;
        r.chrom  = chrom;
        r.bin    = sel;
        r.count  = bin_tally.exists(slot) ? bin_tally[slot] : 32'd0;
      end
      REQ_COUNT: begin
        r.chrom = chrom;
        lo      = (a < b) ? a : b;
        hi      = (a < b) ? b : a;
        len     = 64'(chrom_len[chrom]);
        iv      = (interval_q == '0) ? 64'd1 : 64'(interval_q);
        minus   = (strand == STRAND_MINUS);
        if (req_data[IN_NEG_LO]) begin
          r.status = ST_BEFORE;
        end else if (hi > len) begin
          r.status = ST_PAST;
        end else if (strand[1] && drop_unknown_q) begin
          r.status = ST_DROPPED;
        end else begin
          r.assumed = strand[1];
          // all ones means half the interval; any other negative shift means none
          if (shift_q == SHIFT_DEFAULT) shift = iv / 2;
          else if (shift_q[SHIFT_W-1]) shift = 64'd0;
          else shift = 64'(shift_q);
          if (five_prime_q) pos = minus ? hi : lo;
          else pos = (lo + hi) >> 1;
          if (minus) pos = (pos < shift) ? 64'd0 : pos - shift;
          else pos = pos + shift;
          if (pos > len) pos = len;
          bin   = pos / iv;
          r.bin = bin[15:0];
          if (bin < 64'(BINS_PER_CHROM_DEF)) begin
            slot  = {chrom, bin[15:0]};
            tally = bin_tally.exists(slot) ? bin_tally[slot] : 32'd0;
            if (tally == '1) r.sat = 1'b1;
            else tally = tally + 32'd1;
            bin_tally[slot] = tally;
            r.status = ST_COUNTED;
            r.count  = tally;
          end
        end
      end
      default: ;  // spare request kind: range status, all else zero
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      interval_q     = BIN_INTERVAL_RST;
      shift_q        = SHIFT_DEFAULT;
      five_prime_q   = 1'b0;
      drop_unknown_q = 1'b0;
      foreach (chrom_len[i]) chrom_len[i] = '0;
      bin_tally.delete();
      pending_results.delete();
      failures        = 0;
      pending         = 0;
      results_checked = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BIN_INTERVAL: interval_q     = cfg_wdata[IV_W-1:0];
          REG_READ_SHIFT:   shift_q        = cfg_wdata;
          REG_FIVE_PRIME:   five_prime_q   = cfg_wdata[0];
          REG_DROP_UNKNOWN: drop_unknown_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", m_tuser);
          failures++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("out_chrom", 32'(want.chrom), 32'(m_tdata[OUT_CHROM_LO +: 2]));
          check_field("out_bin", 32'(want.bin), 32'(m_tdata[OUT_BIN_LO +: 16]));
          check_field("bin_count", want.count, m_tdata[OUT_COUNT_LO +: 32]);
          check_field("count_saturated", 32'(want.sat), 32'(m_tdata[OUT_SAT_LO]));
          check_field("strand_assumed", 32'(want.assumed), 32'(m_tdata[OUT_ASSUMED_LO]));
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.insert(pending_results.size(), predict_bin_update(s_tuser, s_tdata));
      end
      pending = pending_results.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the histogram testbench: clock, reset, register settings, request traffic, verdict.
module testbench;
  import rpbh_pkg::*;

  localparam int PHASES          = 8;
  localparam int RANDOM_PER_PHASE = 55;
  // the count store sweep after reset keeps the request side closed until every entry is cleared
  localparam int QUIET_LIMIT     = 800000;

  localparam logic [1:0] REQ_SPARE      = 2'd3;
  localparam logic [1:0] STRAND_UNKNOWN = 2'd2;
  localparam logic [1:0] STRAND_ODD     = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [SHIFT_W-1:0]     cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [2:0]             m_tuser;

  int failures, pending, results_checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;
  int quiet_cycles = 0;
  logic [31:0] len_known [CHROM_SLOTS] = '{default: '0};

  // Settings per phase; shifts 17'h1FFFE and 17'h10000 are negative values other
  // than all ones, which must act as no shift.
  logic [IV_W-1:0]    phase_interval [PHASES] = '{16'd200, 16'd1, 16'd65535, 16'd0,
                                                  16'd37, 16'd1000, 16'd7, 16'd200};
  logic [SHIFT_W-1:0] phase_shift [PHASES] = '{SHIFT_DEFAULT, 17'd0, 17'd65535, SHIFT_DEFAULT,
                                               17'h1FFFE, 17'h10000, 17'd65535, 17'd50};
  logic               phase_five_prime [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                                    1'b0, 1'b1, 1'b1, 1'b0};
  logic               phase_drop [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0,
                                              1'b0, 1'b1, 1'b0, 1'b1};
  idle_mode_t         phase_mode [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                              IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

  read_position_binning_histogram_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  bin_histogram_checker hist_chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .failures(failures), .pending(pending), .results_checked(results_checked)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [1:0] chrom,
                              input logic [31:0] first, input logic [31:0] second,
                              input logic neg, input logic [1:0] strand,
                              input logic [15:0] sel, input logic [31:0] lenv);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_CHROM_LO +: 2]   = chrom;
    d[IN_FIRST_LO +: 32]  = first;
    d[IN_SECOND_LO +: 32] = second;
    d[IN_NEG_LO]          = neg;
    d[IN_STRAND_LO +: 2]  = strand;
    d[IN_SEL_LO +: 16]    = sel;
    d[IN_LEN_LO +: 32]    = lenv;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= req;
    // s_tready settles between edges; sample it at the falling edge
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (req == REQ_LOAD) len_known[chrom] = lenv;
    n_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SHIFT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic directed_requests();
    send_request(REQ_LOAD, 2'd0, '0, '0, 1'b0, STRAND_PLUS, '0, 32'd1000);
    send_request(REQ_LOAD, 2'd1, '0, '0, 1'b0, STRAND_PLUS, '0, 32'hFFFF_FFFF);
    send_request(REQ_LOAD, 2'd2, '0, '0, 1'b0, STRAND_PLUS, '0, 32'd5000);
    send_request(REQ_LOAD, 2'd3, '0, '0, 1'b0, STRAND_PLUS, '0, 32'd0);
    send_request(REQ_COUNT, 2'd0, 32'd100, 32'd300, 1'b0, STRAND_PLUS, '0, '0);
    // reversed coordinates on the minus strand
    send_request(REQ_COUNT, 2'd0, 32'd300, 32'd100, 1'b0, STRAND_MINUS, '0, '0);
    send_request(REQ_COUNT, 2'd0, 32'd50, 32'd60, 1'b0, STRAND_UNKNOWN, '0, '0);
    send_request(REQ_COUNT, 2'd0, 32'd50, 32'd60, 1'b0, STRAND_ODD, '0, '0);
    send_request(REQ_COUNT, 2'd0, 32'd10, 32'd20, 1'b1, STRAND_PLUS, '0, '0);
    send_request(REQ_COUNT, 2'd0, 32'd10, 32'd1001, 1'b0, STRAND_PLUS, '0, '0);
    // shifted past the end: clamp to the chromosome length
    send_request(REQ_COUNT, 2'd0, 32'd1000, 32'd1000, 1'b0, STRAND_PLUS, '0, '0);
    // minus shift below zero: hold at zero
    send_request(REQ_COUNT, 2'd0, 32'd0, 32'd0, 1'b0, STRAND_MINUS, '0, '0);
    send_request(REQ_COUNT, 2'd1, 32'd0, 32'd0, 1'b0, STRAND_PLUS, '0, '0);
    send_request(REQ_COUNT, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STRAND_PLUS, '0, '0);
    send_request(REQ_COUNT, 2'd3, 32'd0, 32'd0, 1'b0, STRAND_PLUS, '0, '0);
    send_request(REQ_COUNT, 2'd3, 32'd0, 32'd1, 1'b0, STRAND_MINUS, '0, '0);
    send_request(REQ_READ, 2'd0, '0, '0, 1'b0, STRAND_PLUS, 16'd1, '0);
    send_request(REQ_READ, 2'd0, '0, '0, 1'b0, STRAND_PLUS, 16'd0, '0);
    send_request(REQ_READ, 2'd0, '0, '0, 1'b0, STRAND_PLUS, 16'hFFFF, '0);
    send_request(REQ_READ, 2'd1, '0, '0, 1'b0, STRAND_PLUS, 16'd0, '0);
    send_request(REQ_SPARE, 2'd3, '1, '1, 1'b1, STRAND_ODD, '1, '1);
  endtask

  task automatic random_request();
    int          roll;
    logic [1:0]  chrom, strand;
    logic [31:0] first, second, lenv;
    logic [15:0] sel;
    logic        neg;
    roll   = $urandom_range(0, 99);
    chrom  = 2'($urandom_range(0, 3));
    strand = 2'($urandom_range(0, 3));
    first  = $urandom;
    second = $urandom;
    sel    = 16'($urandom);
    lenv   = $urandom;
    neg    = 1'b0;
    if (roll < 3) begin
      send_request(REQ_SPARE, chrom, first, second, 1'($urandom_range(0, 1)), strand, sel, lenv);
    end else if (roll < 15) begin
      case ($urandom_range(0, 4))
        0, 1: lenv = $urandom_range(0, 65535);
        2, 3: lenv = $urandom_range(0, 20000000);
        default: ;
      endcase
      send_request(REQ_LOAD, chrom, first, second, 1'($urandom_range(0, 1)), strand, sel, lenv);
    end else if (roll < 33) begin
      // low bins are where the counts pile up
      if ($urandom_range(0, 9) < 7) sel = 16'($urandom_range(0, 63));
      send_request(REQ_READ, chrom, first, second, 1'($urandom_range(0, 1)), strand, sel, lenv);
    end else begin
      if ($urandom_range(0, 99) >= 15) begin
        first  = $urandom_range(0, len_known[chrom]);
        second = $urandom_range(0, len_known[chrom]);
      end
      neg = ($urandom_range(0, 99) < 5);
      send_request(REQ_COUNT, chrom, first, second, neg, strand, sel, lenv);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_BIN_INTERVAL, SHIFT_W'(phase_interval[p]));
      write_reg(REG_READ_SHIFT, phase_shift[p]);
      write_reg(REG_FIVE_PRIME, SHIFT_W'(phase_five_prime[p]));
      write_reg(REG_DROP_UNKNOWN, SHIFT_W'(phase_drop[p]));
      cfg_wr_en <= 1'b0;
      send_idle_pct = (phase_mode[p] == IDLE_SENDER) ? 81 : (phase_mode[p] == IDLE_BOTH) ? 32 : 0;
      stall_pct = (phase_mode[p] == IDLE_RECEIVER) ? 81 : (phase_mode[p] == IDLE_BOTH) ? 32 : 0;
      if (p == 0) directed_requests();
      repeat (RANDOM_PER_PHASE) random_request();
    end
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Covered %0d requests (counts, loads, readouts, spare kind) under %0d settings",
             n_sent, PHASES);
    $display("of interval, shift, end choice and strand policy; %0d results compared",
             results_checked);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
